// ===== rtl/cass_pkg.sv =====
// Shared types, codes and constants of the cluster access sector splitter.
package cass_pkg;

  localparam int MAX_CLUSTER_SECTORS = 64;
  localparam int MAX_SECTOR_BYTES    = 4096;
  localparam int MIN_SECTOR_BYTES    = 512;

  localparam int LBA_W   = 28;
  localparam int POS_W   = 32;
  localparam int CNT_W   = 32;
  localparam int SB_W    = 13;
  localparam int CS_W    = 7;
  localparam int OFF_W   = 12;
  localparam int TOT_W   = 19;
  localparam int CSIZE_W = 19;
  localparam int SEC_W   = 7;
  localparam int QIDX_W  = 3;
  localparam int QDEPTH  = 2;

  localparam logic [LBA_W-1:0] FIRST_DATA_CLUSTER = 28'd2;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [2:0] KIND_DIRECT_READ = 3'd0;
  localparam logic [2:0] KIND_EXTRACT     = 3'd1;
  localparam logic [2:0] KIND_FULL_WRITE  = 3'd2;
  localparam logic [2:0] KIND_RMW         = 3'd3;
  localparam logic [2:0] KIND_ZERO        = 3'd4;

  localparam logic [1:0] REG_DATA_START      = 2'd0;
  localparam logic [1:0] REG_SECTOR_BYTES    = 2'd1;
  localparam logic [1:0] REG_CLUSTER_SECTORS = 2'd2;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [LBA_W-1:0] cluster_number;
    logic [POS_W-1:0] byte_position;
    logic [CNT_W-1:0] byte_count;
  } in_req_t;

  typedef struct packed {
    logic [LBA_W-1:0] sector_lba;
    logic [OFF_W-1:0] offset_in_sector;
    logic [SB_W-1:0]  chunk_length;
    logic [2:0]       access_kind;
    logic [TOT_W-1:0] bytes_so_far;
    logic             last_command;
  } out_cmd_t;

  // One classified request, ready for the command sequencer.
  typedef struct packed {
    logic [1:0]       op;
    logic [LBA_W-1:0] base_lba;
    logic [SEC_W-1:0] start_sec;
    logic [OFF_W-1:0] start_byte;
    logic [CNT_W-1:0] count;
    logic [SB_W-1:0]  sb;
    logic [CS_W-1:0]  cs;
  } job_t;

  function automatic logic [SB_W-1:0] sat_sector_bytes(input logic [SB_W-1:0] v);
    logic [SB_W-1:0] r;
    r = v;
    if (v < SB_W'(MIN_SECTOR_BYTES)) r = SB_W'(MIN_SECTOR_BYTES);
    if (v > SB_W'(MAX_SECTOR_BYTES)) r = SB_W'(MAX_SECTOR_BYTES);
    return r;
  endfunction

  function automatic logic [CS_W-1:0] sat_cluster_sectors(input logic [CS_W-1:0] v);
    logic [CS_W-1:0] r;
    r = v;
    if (v == '0) r = CS_W'(1);
    if (v > CS_W'(MAX_CLUSTER_SECTORS)) r = CS_W'(MAX_CLUSTER_SECTORS);
    return r;
  endfunction

endpackage

// ===== rtl/cass_front.sv =====
// Request front end: base LBA, position modulo cluster size, start sector and byte.
module cass_front import cass_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_push,
  input  in_req_t          req_data,
  output logic             req_busy,
  input  logic [SB_W-1:0]  sb,
  input  logic [CS_W-1:0]  cs,
  input  logic [LBA_W-1:0] data_start,
  output logic             job_push,
  output job_t             job_data,
  input  logic             job_full
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_REM  = 2'd1;
  localparam logic [1:0] F_QUO  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [1:0]         op_r;
  logic [LBA_W-1:0]   prod_r;
  logic [CNT_W-1:0]   count_r;
  logic [POS_W-1:0]   pos_sh_r;
  logic [CSIZE_W-1:0] csize_r;
  logic [CSIZE_W-1:0] rem_r;
  logic [4:0]         step_r;
  logic [SEC_W-1:0]   sec_r;
  logic [SB_W-1:0]    sb_r;
  logic [CS_W-1:0]    cs_r;

  logic [CSIZE_W:0]   rem_trial;
  logic [CSIZE_W-1:0] rem_step;
  logic [CSIZE_W-1:0] quo_div;
  logic               accept;

  assign accept   = (state_r == F_IDLE) && req_push;
  assign req_busy = (state_r != F_IDLE);

  // One bit of the position per cycle through a restoring remainder.
  assign rem_trial = {rem_r, pos_sh_r[POS_W-1]};
  assign rem_step  = (rem_trial >= {1'b0, csize_r}) ?
                     CSIZE_W'(rem_trial - {1'b0, csize_r}) : CSIZE_W'(rem_trial);
  assign quo_div   = CSIZE_W'({6'd0, sb_r} << step_r[2:0]);

  assign job_push            = (state_r == F_PUSH) && !job_full;
  assign job_data.op         = op_r;
  assign job_data.base_lba   = LBA_W'(data_start + prod_r);
  assign job_data.start_sec  = sec_r;
  assign job_data.start_byte = rem_r[OFF_W-1:0];
  assign job_data.count      = count_r;
  assign job_data.sb         = sb_r;
  assign job_data.cs         = cs_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (req_push && req_data.opcode != OP_NONE) begin
          state_nxt = (req_data.opcode == OP_CLEAR) ? F_PUSH : F_REM;
        end
      end
      F_REM:  if (step_r == '0) state_nxt = F_QUO;
      F_QUO:  if (step_r == '0) state_nxt = F_PUSH;
      F_PUSH: if (!job_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= req_data.opcode;
      prod_r   <= LBA_W'(cs * LBA_W'(req_data.cluster_number - FIRST_DATA_CLUSTER));
      count_r  <= req_data.byte_count;
      pos_sh_r <= req_data.byte_position;
      // The cluster size needs the full 19 bits, up to 4096 * 64.
      csize_r  <= CSIZE_W'(sb) * CSIZE_W'(cs);
      rem_r    <= '0;
      step_r   <= 5'd31;
      sec_r    <= '0;
      sb_r     <= sb;
      cs_r     <= cs;
    end else if (state_r == F_REM) begin
      rem_r    <= rem_step;
      pos_sh_r <= {pos_sh_r[POS_W-2:0], 1'b0};
      step_r   <= (step_r == '0) ? 5'd5 : step_r - 5'd1;
    end else if (state_r == F_QUO) begin
      // Sector index is below 64, so six compare-subtract steps find it.
      if (rem_r >= quo_div) begin
        rem_r                <= rem_r - quo_div;
        sec_r[step_r[2:0]]   <= 1'b1;
      end
      step_r <= step_r - 5'd1;
    end
  end

endmodule

// ===== rtl/cass_queue.sv =====
// Short job queue between the front end and the command sequencer.
module cass_queue import cass_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t pop_data,
  output logic empty
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int FILL_W = $clog2(QDEPTH + 1);

  job_t              entries_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [FILL_W-1:0] fill_r;
  logic              do_push;
  logic              do_pop;

  assign full     = (fill_r == FILL_W'(QDEPTH));
  assign empty    = (fill_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/cass_back.sv =====
// Command sequencer: walks the sectors of one job and emits one command per cycle unless the output is held.
module cass_back import cass_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  job_t     job_data,
  input  logic     job_empty,
  output logic     job_pop,
  output logic     cmd_valid,
  output out_cmd_t cmd_data,
  input  logic     cmd_pop
);

  logic             active_r;
  logic [1:0]       op_r;
  logic [LBA_W-1:0] lba_r;
  logic [SEC_W-1:0] sec_r;
  logic [OFF_W-1:0] byte_r;
  logic [CNT_W-1:0] count_r;
  logic [TOT_W-1:0] total_r;
  logic [SB_W-1:0]  sb_r;
  logic [CS_W-1:0]  cs_r;
  logic             out_valid_r;
  out_cmd_t         out_data_r;

  logic [SB_W-1:0]  left;
  logic [SB_W-1:0]  len;
  logic [CNT_W-1:0] count_nxt;
  logic [TOT_W-1:0] total_nxt;
  logic             end_of_cluster;
  logic             emit;
  out_cmd_t         cmd;

  assign job_pop   = !active_r && !job_empty;
  assign emit      = active_r && (!out_valid_r || cmd_pop);
  assign cmd_valid = out_valid_r;
  assign cmd_data  = out_data_r;

  always_comb begin
    left           = sb_r - {1'b0, byte_r};
    end_of_cluster = ({1'b0, sec_r} + 8'd1) == {1'b0, cs_r};
    if (op_r == OP_CLEAR) begin
      len = sb_r;
    end else if (count_r < {{(CNT_W-SB_W){1'b0}}, left}) begin
      len = count_r[SB_W-1:0];
    end else begin
      len = left;
    end
    count_nxt = count_r - {{(CNT_W-SB_W){1'b0}}, len};
    total_nxt = total_r + {{(TOT_W-SB_W){1'b0}}, len};

    cmd.sector_lba       = lba_r;
    cmd.offset_in_sector = (op_r == OP_CLEAR) ? '0 : byte_r;
    cmd.chunk_length     = len;
    cmd.bytes_so_far     = total_nxt;
    unique case (op_r)
      OP_READ: begin
        cmd.access_kind  = (byte_r == '0) ? KIND_DIRECT_READ : KIND_EXTRACT;
        cmd.last_command = (count_nxt == '0) || end_of_cluster;
      end
      OP_WRITE: begin
        cmd.access_kind  = (byte_r == '0 && len == sb_r) ? KIND_FULL_WRITE : KIND_RMW;
        cmd.last_command = (count_nxt == '0) || end_of_cluster;
      end
      default: begin
        cmd.access_kind  = KIND_ZERO;
        cmd.last_command = end_of_cluster;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (job_pop) begin
        active_r <= 1'b1;
      end else if (emit && cmd.last_command) begin
        active_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (cmd_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      op_r    <= job_data.op;
      lba_r   <= LBA_W'(job_data.base_lba + {{(LBA_W-SEC_W){1'b0}}, job_data.start_sec});
      sec_r   <= job_data.start_sec;
      byte_r  <= job_data.start_byte;
      count_r <= job_data.count;
      total_r <= '0;
      sb_r    <= job_data.sb;
      cs_r    <= job_data.cs;
    end else if (emit) begin
      lba_r   <= lba_r + 1'b1;
      sec_r   <= sec_r + 1'b1;
      byte_r  <= '0;
      count_r <= count_nxt;
      total_r <= total_nxt;
    end
    if (emit) begin
      out_data_r <= cmd;
    end
  end

endmodule

// ===== rtl/cluster_access_sector_splitter.sv =====
// Top level of the cluster access sector splitter: configuration registers and the three parts.
// A read or write request is taken by the front end, which then finds the bit-serial
// remainder of the byte position by the cluster size and then the sector index, and hands
// it on, waiting while the job queue is full; a clear request skips both steps. The
// sequencer then emits one sector command per cycle while the result side pops, and a
// two-entry job queue lets the front end work on the next request meanwhile. Sector
// size and cluster sectors are clamped to 512..4096 and 1..64 when used. Configuration
// writes are always taken and must only happen while no request is in flight.
module cluster_access_sector_splitter import cass_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  in_req_t          in_data,
  output logic             in_full,
  output logic             out_empty,
  output out_cmd_t         out_data,
  input  logic             out_pop,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [LBA_W-1:0] cfg_data
);

  logic [LBA_W-1:0] data_start_r;
  logic [SB_W-1:0]  sector_bytes_r;
  logic [CS_W-1:0]  cluster_sectors_r;

  logic job_push;
  job_t job_in;
  logic job_full;
  logic job_pop;
  job_t job_out;
  logic job_empty;
  logic cmd_valid;

  assign cfg_ready = 1'b1;
  assign out_empty = !cmd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_start_r      <= '0;
      sector_bytes_r    <= SB_W'(MIN_SECTOR_BYTES);
      cluster_sectors_r <= CS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DATA_START:      data_start_r      <= cfg_data;
        REG_SECTOR_BYTES:    sector_bytes_r    <= cfg_data[SB_W-1:0];
        REG_CLUSTER_SECTORS: cluster_sectors_r <= cfg_data[CS_W-1:0];
        default: ;
      endcase
    end
  end

  cass_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_push   (in_push),
    .req_data   (in_data),
    .req_busy   (in_full),
    .sb         (sat_sector_bytes(sector_bytes_r)),
    .cs         (sat_cluster_sectors(cluster_sectors_r)),
    .data_start (data_start_r),
    .job_push   (job_push),
    .job_data   (job_in),
    .job_full   (job_full)
  );

  cass_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (job_empty)
  );

  cass_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_data  (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .cmd_valid (cmd_valid),
    .cmd_data  (out_data),
    .cmd_pop   (out_pop)
  );

  a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(job_push && job_full))
    else $error("job queue written while full");

  a_no_queue_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(job_pop && job_empty))
    else $error("job queue read while empty");

  a_zero_fill_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.access_kind == KIND_ZERO) |-> out_data.offset_in_sector == '0)
    else $error("zero-fill command with nonzero offset");

  a_idle_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (!in_full && out_empty))
    else $error("block not idle after reset");

endmodule
